[src/sfs_pkg.sv]
package sfs_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int ADV_W       = 16;
  localparam int TURN_STEP   = 2;
  localparam int RESET_SPEED = 64;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIDIRECTIONAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_REVERSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONCE_MODE     = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic direct;
    logic due;
  } dp_status_t;

endpackage

[src/sfs_if.sv]
interface sfs_in_if #(
  parameter int TICK_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [TICK_BITS:0]   tick_amount;
  logic                        restart;

  modport source (output valid, output tick_amount, output restart, input ready);
  modport sink   (input valid, input tick_amount, input restart, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; #(
  parameter int FRAME_BITS = 8
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAME_BITS:0]  current_frame;
  logic                        finished;
  logic [ADV_W-1:0]            advances;
  logic                        moving_back;

  modport source (output valid, output current_frame, output finished,
                  output advances, output moving_back, input ready);
  modport sink   (input valid, input current_frame, input finished,
                  input advances, input moving_back, output ready);
endinterface

[src/sprite_frame_sequencer_top.sv]
// Channel   Dir  Payload                                          Transfer
// items     in   tick_amount, restart                             valid && ready
// results   out  current_frame, finished, advances, moving_back   valid && ready
// cfg       in   cfg_index, cfg_data                              cfg_we
//
// Idle takes an item, loop steps one frame per cycle while the countdown is
// due, done loads the result; a restart or an item at speed 0 skips loop.
// A new item is taken once the previous result sits in the output register.
// Reset is synchronous and restores the register defaults and the start frame.
// A stalled result holds the output register; the next result waits in done.
module sprite_frame_sequencer_top import sfs_pkg::*; #(
  parameter int FRAME_BITS = 8,
  parameter int TICK_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  sfs_in_if.sink                      items,
  sfs_out_if.source                   results,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [((TICK_BITS > FRAME_BITS + 1) ? TICK_BITS : FRAME_BITS + 1)-1:0] cfg_data
);

  localparam int CFG_W = (TICK_BITS > FRAME_BITS + 1) ? TICK_BITS : FRAME_BITS + 1;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfs_datapath #(
    .FRAME_BITS (FRAME_BITS),
    .TICK_BITS  (TICK_BITS),
    .CFG_W      (CFG_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tick_amount   (items.tick_amount),
    .restart       (items.restart),
    .cmd           (cmd),
    .status        (status),
    .current_frame (results.current_frame),
    .finished      (results.finished),
    .advances      (results.advances),
    .moving_back   (results.moving_back)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("item taken while previous item in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!results.valid || results.ready))
    else $error("pending result overwritten");

  a_step_due: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (status.due && !cmd.accept && !cmd.out_load))
    else $error("frame step without due countdown");

endmodule

[src/sfs_ctrl.sv]
module sfs_ctrl import sfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = status.direct ? ST_DONE : ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (status.due) begin
          cmd.step = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[src/sfs_datapath.sv]
module sfs_datapath import sfs_pkg::*; #(
  parameter int FRAME_BITS = 8,
  parameter int TICK_BITS  = 16,
  parameter int CFG_W      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic signed [TICK_BITS:0]   tick_amount,
  input  logic                        restart,
  input  ctrl_cmd_t                   cmd,
  output dp_status_t                  status,
  output logic signed [FRAME_BITS:0]  current_frame,
  output logic                        finished,
  output logic [ADV_W-1:0]            advances,
  output logic                        moving_back
);

  localparam int FW  = FRAME_BITS + 1;
  localparam int FX  = FRAME_BITS + 3;
  localparam int CDW = TICK_BITS + 2;
  localparam logic signed [FX-1:0] ONE = FX'(1);
  localparam logic signed [FX-1:0] TWO = FX'(TURN_STEP);
  localparam logic [ADV_W-1:0] ADV_MAX = '1;

  logic [FW-1:0]          frame_count;
  logic [FRAME_BITS-1:0]  first_frame;
  logic signed [FW-1:0]   last_frame;
  logic [TICK_BITS-1:0]   speed;
  logic                   bidirectional;
  logic                   start_reverse;
  logic                   once_mode;

  logic signed [FW-1:0]   frame_index;
  logic                   backward;
  logic signed [CDW-1:0]  countdown;
  logic                   done_flag;
  logic [ADV_W-1:0]       adv;

  logic signed [FX-1:0]   fi_x;
  logic signed [FX-1:0]   first_x;
  logic signed [FX-1:0]   count_x;
  logic signed [FX-1:0]   last_x;
  logic signed [FX-1:0]   end_x;
  logic signed [FX-1:0]   frame_step;
  logic                   back_step;
  logic                   done_step;
  logic                   past;
  logic [TICK_BITS:0]     t_raw;
  logic [TICK_BITS:0]     mag;

  assign fi_x    = {{2{frame_index[FW-1]}}, frame_index};
  assign first_x = {3'b000, first_frame};
  assign count_x = {2'b00, frame_count};
  assign last_x  = {{2{last_frame[FW-1]}}, last_frame};
  assign end_x   = last_frame[FW-1] ? (count_x - ONE) : last_x;

  assign t_raw = tick_amount;
  assign mag   = t_raw[TICK_BITS] ? (~t_raw + (TICK_BITS + 1)'(1)) : t_raw;

  assign status.direct = restart || (speed == '0);
  assign status.due    = countdown[CDW-1] || (countdown == '0);

  always_comb begin
    back_step = backward;
    done_step = done_flag;
    past      = 1'b0;
    if (backward) begin
      frame_step = fi_x - ONE;
      if (frame_step < first_x) begin
        if (bidirectional) begin
          back_step  = 1'b0;
          frame_step = frame_step + TWO;
        end else begin
          frame_step = end_x;
        end
        if (once_mode) begin
          done_step = 1'b1;
        end
      end
    end else begin
      frame_step = fi_x + ONE;
      past = last_frame[FW-1] ? (frame_step >= count_x) : (frame_step > last_x);
      if (past) begin
        if (bidirectional) begin
          back_step  = 1'b1;
          frame_step = frame_step - TWO;
        end else begin
          frame_step = first_x;
          if (once_mode) begin
            done_step = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= FW'(1);
      first_frame   <= '0;
      last_frame    <= '1;
      speed         <= TICK_BITS'(RESET_SPEED);
      bidirectional <= 1'b0;
      start_reverse <= 1'b0;
      once_mode     <= 1'b0;
      frame_index   <= '0;
      backward      <= 1'b0;
      countdown     <= CDW'(RESET_SPEED);
      done_flag     <= 1'b0;
      adv           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_COUNT:   frame_count   <= cfg_data[FW-1:0];
          REG_FIRST_FRAME:   first_frame   <= cfg_data[FRAME_BITS-1:0];
          REG_LAST_FRAME:    last_frame    <= cfg_data[FW-1:0];
          REG_SPEED:         speed         <= cfg_data[TICK_BITS-1:0];
          REG_BIDIRECTIONAL: bidirectional <= cfg_data[0];
          REG_START_REVERSE: start_reverse <= cfg_data[0];
          REG_ONCE_MODE: begin
            once_mode <= cfg_data[0];
            done_flag <= 1'b0;
            if (cfg_data[0]) begin
              frame_index <= {1'b0, first_frame};
            end
          end
          default: ;
        endcase
      end
      if (cmd.accept) begin
        adv <= '0;
        if (restart) begin
          frame_index <= {1'b0, first_frame};
          backward    <= start_reverse;
          done_flag   <= 1'b0;
          countdown   <= {2'b00, speed};
        end else if (speed != '0) begin
          countdown <= countdown - signed'({1'b0, mag});
        end
      end
      if (cmd.step) begin
        frame_index <= frame_step[FW-1:0];
        backward    <= back_step;
        done_flag   <= done_step;
        countdown   <= countdown + signed'({2'b00, speed});
        if (adv != ADV_MAX) begin
          adv <= adv + ADV_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      current_frame <= frame_index;
      finished      <= done_flag;
      advances      <= adv;
      moving_back   <= backward;
    end
  end

endmodule
